// ===== hw/rtl/rems_pkg.sv =====
`timescale 1ns / 1ps
package rems_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_REPLICA = 2'd0,
      OP_LOAD_BETA    = 2'd1,
      OP_ATTEMPT      = 2'd2,
      OP_READ_SLOT    = 2'd3
   } op_type;

   localparam logic [1:0] CSR_NUM_REPLICAS    = 2'd0;
   localparam logic [1:0] CSR_NPT_MODE        = 2'd1;
   localparam logic [1:0] CSR_TARGET_PRESSURE = 2'd2;

   localparam int EXP_TERMS = 15;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   // exp(-2^k / 1024) in Q0.32
   function automatic logic [31:0] exp_entry(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd0:    r = 32'd4290775039;
         4'd1:    r = 32'd4286586875;
         4'd2:    r = 32'd4278222805;
         4'd3:    r = 32'd4261543595;
         4'd4:    r = 32'd4228380000;
         4'd5:    r = 32'd4162825044;
         4'd6:    r = 32'd4034748382;
         4'd7:    r = 32'd3790295335;
         4'd8:    r = 32'd3344923893;
         4'd9:    r = 32'd2605029347;
         4'd10:   r = 32'd1580030169;
         4'd11:   r = 32'd581260615;
         4'd12:   r = 32'd78665070;
         4'd13:   r = 32'd1440801;
         4'd14:   r = 32'd483;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // request from the sequencer to the shared multiplier
   typedef struct packed {
      logic        start;
      logic [32:0] a;
      logic [50:0] b;
   } mul_req_type;

endpackage

// ===== hw/rtl/replica_exchange_metropolis_swap.sv =====
`timescale 1ns / 1ps
// Parallel-tempering swap engine. Loads (ops 0, 1) return nothing and leave
// req_ready high. A slot read (op 3) passes through S_READ, which registers its
// result and raises rsp_valid. An attempt (op 2) runs every multiply
// (P*dV, dBeta*sum, each exp table factor) through the one shared 33x51
// multiplier. An attempt decides without a product when delta <= 0 and stops
// after the dBeta*sum product when exp(-delta) underflows to zero; otherwise it
// walks over all 15 bits of the scaled delta with one product per set bit; npt
// mode adds the pressure product. The block holds req_ready low while an item
// is in flight; the result register frees the datapath only after rsp is taken,
// and req_ready returns the cycle after that.
module replica_exchange_metropolis_swap #(
   parameter int MAX_REPLICAS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [3:0]           req_index,
   input  logic signed [31:0]   req_energy,
   input  logic [31:0]          req_volume,
   input  logic [31:0]          req_beta_value,
   input  logic [31:0]          req_random_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_pair_slot,
   output logic [3:0]           rsp_replica_low,
   output logic [3:0]           rsp_replica_high,
   output logic                 rsp_accepted,
   output logic                 rsp_round_done,
   output logic [31:0]          rsp_attempt_count,
   output logic [31:0]          rsp_exchange_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import rems_pkg::*;

   localparam int IW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
   localparam int NW = $clog2(MAX_REPLICAS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_PICK, S_FETCH, S_PV_MUL, S_PV_WAIT, S_DB_MUL,
      S_DB_WAIT, S_EXP_STEP, S_EXP_WAIT, S_DECIDE, S_RESP
   } state_type;

   // configuration
   logic [4:0]  num_rep_ff;
   logic        npt_ff;
   logic [31:0] pressure_ff;

   // stores
   logic [IW-1:0] rep_in_slot_ff [MAX_REPLICAS];
   logic [31:0]   energy_mem [MAX_REPLICAS];
   logic [31:0]   volume_mem [MAX_REPLICAS];
   logic [31:0]   beta_mem   [MAX_REPLICAS];
   logic [31:0]   attempts_ff  [MAX_REPLICAS];
   logic [31:0]   exchanges_ff [MAX_REPLICAS];
   logic          parity_ff, in_round_ff;
   logic [IW:0]   next_pair_ff;

   state_type   state_ff;
   logic [3:0]  idx_ff;
   logic [31:0] rnd_ff;
   logic [IW:0] m_ff;
   logic [IW-1:0] ri_ff, rj_ff;
   logic signed [49:0] sum_ff;   // E[i]-E[j] (+ floored P*dV)
   logic signed [33:0] dv_ff;
   logic signed [32:0] db_ff;
   logic [31:0] ei_ff, ej_ff;
   logic [31:0] vi_ff, vj_ff;
   logic [31:0] bl_ff, bh_ff;
   logic        neg_ff;
   logic [14:0] q_ff;
   logic [3:0]  k_ff;
   logic [32:0] acc_ff;

   // response register
   logic        rsp_valid_ff;
   logic [3:0]  o_slot_ff, o_low_ff, o_high_ff;
   logic        o_acc_ff, o_done_ff;
   logic [31:0] o_att_ff, o_exc_ff;

   mul_req_type mreq;
   logic        mdone;
   logic [83:0] mprod;

   rems_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mreq),
      .done    (mdone),
      .product (mprod)
   );

   // active count clamped to [2, MAX_REPLICAS]
   logic [NW-1:0] n_act;
   always_comb begin
      if (num_rep_ff < 5'd2) n_act = NW'(2);
      else if (32'(num_rep_ff) > MAX_REPLICAS) n_act = NW'(MAX_REPLICAS);
      else n_act = NW'(num_rep_ff);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // combinational helpers
   logic [IW:0] m_start;
   logic signed [65:0] pv_signed;
   logic signed [49:0] pv_floor;
   logic [32:0] a_mag;
   logic [50:0] b_mag;
   logic [63:0] delta_mag;
   logic [32:0] thr;
   logic [31:0] att_next, exc_next;
   logic        accept;
   logic [IW:0] m_next;
   logic        last_pair;
   logic        read_ok, read_pair;

   always_comb begin
      m_start = (!in_round_ff || (32'(next_pair_ff) + 1 >= 32'(n_act)))
         ? ((parity_ff && n_act != NW'(2)) ? (IW+1)'(1) : '0) : next_pair_ff;
      a_mag = db_ff[32] ? 33'(-db_ff) : 33'(db_ff);
      // |sum| stays below 2^49
      b_mag = sum_ff[49] ? 51'(-sum_ff) : 51'(sum_ff);
      // |P*dV| product with the sign rebuilt, then floor
      pv_signed  = neg_ff ? -$signed({1'b0, mprod[64:0]}) : $signed({1'b0, mprod[64:0]});
      pv_floor   = 50'(pv_signed >>> 16);
      delta_mag  = mprod[63:0];
      thr        = acc_ff;
      accept     = {1'b0, rnd_ff} < thr;
      att_next = (attempts_ff[m_ff[IW-1:0]] == '1) ? '1 : attempts_ff[m_ff[IW-1:0]] + 32'd1;
      exc_next = (exchanges_ff[m_ff[IW-1:0]] == '1) ? '1 : exchanges_ff[m_ff[IW-1:0]] + 32'd1;
      m_next    = m_ff + (IW+1)'(2);
      last_pair = (32'(m_next) + 1 >= 32'(n_act));
      read_ok   = 32'(idx_ff) < MAX_REPLICAS;
      read_pair = read_ok && (32'(idx_ff) + 1 < 32'(n_act));
   end

   always_comb begin
      mreq = '{start: 1'b0, a: '0, b: '0};
      if (state_ff == S_PV_MUL) begin
         mreq.start = 1'b1;
         mreq.a = pressure_ff[31] ? 33'(-{pressure_ff[31], pressure_ff})
                                  : {1'b0, pressure_ff};
         mreq.b = dv_ff[33] ? 51'(-dv_ff) : 51'(dv_ff);
      end else if (state_ff == S_DB_MUL) begin
         mreq.start = 1'b1;
         mreq.a = a_mag;
         mreq.b = b_mag;
      end else if (state_ff == S_EXP_STEP && k_ff < 4'(EXP_TERMS) && q_ff[k_ff]) begin
         mreq.start = 1'b1;
         mreq.a = acc_ff;
         mreq.b = {19'd0, exp_entry(k_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_operation == OP_LOAD_REPLICA && 32'(req_index) < MAX_REPLICAS) begin
         energy_mem[req_index[IW-1:0]] <= req_energy;
         volume_mem[req_index[IW-1:0]] <= req_volume;
      end
      if (req_fire && req_operation == OP_LOAD_BETA && 32'(req_index) < MAX_REPLICAS)
         beta_mem[req_index[IW-1:0]] <= req_beta_value;
      if (state_ff == S_PICK) begin
         ei_ff <= energy_mem[ri_ff];
         ej_ff <= energy_mem[rj_ff];
         vi_ff <= volume_mem[ri_ff];
         vj_ff <= volume_mem[rj_ff];
         bl_ff <= beta_mem[m_ff[IW-1:0]];
         bh_ff <= beta_mem[m_ff[IW-1:0] + IW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rep_ff   <= 5'd16;
         npt_ff       <= 1'b0;
         pressure_ff  <= '0;
         for (int s = 0; s < MAX_REPLICAS; s++) begin
            rep_in_slot_ff[s] <= IW'(s);
            attempts_ff[s]    <= '0;
            exchanges_ff[s]   <= '0;
         end
         parity_ff    <= 1'b0;
         in_round_ff  <= 1'b0;
         next_pair_ff <= '0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_NUM_REPLICAS:    num_rep_ff  <= csr_data[4:0];
               CSR_NPT_MODE:        npt_ff      <= csr_data[0];
               CSR_TARGET_PRESSURE: pressure_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  idx_ff <= req_index;
                  rnd_ff <= req_random_value;
                  case (req_operation)
                     OP_READ_SLOT: state_ff <= S_READ;
                     OP_ATTEMPT:   state_ff <= S_PICK;
                     default:      state_ff <= S_IDLE;
                  endcase
                  if (req_operation == OP_ATTEMPT) begin
                     m_ff        <= m_start;
                     ri_ff       <= rep_in_slot_ff[m_start[IW-1:0]];
                     rj_ff       <= rep_in_slot_ff[m_start[IW-1:0] + IW'(1)];
                     in_round_ff <= 1'b1;
                  end
               end
            end
            S_READ: begin
               o_slot_ff <= idx_ff;
               o_acc_ff  <= 1'b0;
               o_done_ff <= 1'b0;
               if (read_ok) o_low_ff <= 4'(rep_in_slot_ff[idx_ff[IW-1:0]]);
               else o_low_ff <= '0;
               if (read_pair) begin
                  o_high_ff <= 4'(rep_in_slot_ff[idx_ff[IW-1:0] + IW'(1)]);
                  o_att_ff  <= attempts_ff[idx_ff[IW-1:0]];
                  o_exc_ff  <= exchanges_ff[idx_ff[IW-1:0]];
               end else begin
                  o_high_ff <= '0;
                  o_att_ff  <= '0;
                  o_exc_ff  <= '0;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_PICK: state_ff <= S_FETCH;
            S_FETCH: begin
               db_ff  <= $signed({1'b0, bh_ff}) - $signed({1'b0, bl_ff});
               sum_ff <= 50'($signed(ei_ff)) - 50'($signed(ej_ff));
               dv_ff  <= $signed({2'b0, vi_ff}) - $signed({2'b0, vj_ff});
               state_ff <= npt_ff ? S_PV_MUL : S_DB_MUL;
            end
            S_PV_MUL: begin
               neg_ff   <= pressure_ff[31] ^ dv_ff[33];
               state_ff <= S_PV_WAIT;
            end
            S_PV_WAIT: if (mdone) begin
               sum_ff   <= sum_ff + pv_floor;
               state_ff <= S_DB_MUL;
            end
            S_DB_MUL: begin
               acc_ff <= ONE_Q32;
               k_ff   <= '0;
               if (db_ff == '0 || sum_ff == '0 || (db_ff[32] != sum_ff[49]))
                  state_ff <= S_DECIDE;
               else
                  state_ff <= S_DB_WAIT;
            end
            S_DB_WAIT: if (mdone) begin
               // a product of 2^45 or more means exp is zero
               if (mprod[83:45] != '0) begin
                  acc_ff   <= '0;
                  state_ff <= S_DECIDE;
               end else begin
                  q_ff     <= delta_mag[44:30];
                  state_ff <= S_EXP_STEP;
               end
            end
            S_EXP_STEP: begin
               if (k_ff == 4'(EXP_TERMS)) state_ff <= S_DECIDE;
               else if (q_ff[k_ff]) state_ff <= S_EXP_WAIT;
               else k_ff <= k_ff + 4'd1;
            end
            S_EXP_WAIT: if (mdone) begin
               acc_ff   <= 33'(mprod >> 32);
               k_ff     <= k_ff + 4'd1;
               state_ff <= S_EXP_STEP;
            end
            S_DECIDE: begin
               attempts_ff[m_ff[IW-1:0]] <= att_next;
               o_att_ff  <= att_next;
               o_exc_ff  <= accept ? exc_next : exchanges_ff[m_ff[IW-1:0]];
               if (accept) begin
                  exchanges_ff[m_ff[IW-1:0]]        <= exc_next;
                  rep_in_slot_ff[m_ff[IW-1:0]]         <= rj_ff;
                  rep_in_slot_ff[m_ff[IW-1:0] + IW'(1)] <= ri_ff;
               end
               o_slot_ff <= 4'(m_ff);
               o_low_ff  <= 4'(ri_ff);
               o_high_ff <= 4'(rj_ff);
               o_acc_ff  <= accept;
               o_done_ff <= last_pair;
               if (last_pair) begin
                  in_round_ff  <= 1'b0;
                  parity_ff    <= ~parity_ff;
                  next_pair_ff <= '0;
               end else begin
                  next_pair_ff <= m_next;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pair_slot      = o_slot_ff;
   assign rsp_replica_low    = o_low_ff;
   assign rsp_replica_high   = o_high_ff;
   assign rsp_accepted       = o_acc_ff;
   assign rsp_round_done     = o_done_ff;
   assign rsp_attempt_count  = o_att_ff;
   assign rsp_exchange_count = o_exc_ff;
endmodule

// ===== hw/rtl/rems_mul.sv =====
`timescale 1ns / 1ps
// shared unsigned 33x51 multiplier, accumulating 17-bit partial products one at a time
module rems_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rems_pkg::mul_req_type req,
   output logic                 done,
   output logic [83:0]          product
);
   import rems_pkg::*;

   logic [1:0]  step_ff;
   logic [1:0]  step_in;
   logic [32:0] a_ff;
   logic [50:0] b_ff;
   logic [83:0] acc_ff, acc_in;
   logic        done_ff, done_in;
   logic [16:0] b_part;
   logic [49:0] pp;

   always_comb begin
      case (step_ff)
         2'd1:    b_part = b_ff[16:0];
         2'd2:    b_part = b_ff[33:17];
         default: b_part = b_ff[50:34];
      endcase
      pp      = a_ff * b_part;
      step_in = step_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (req.start) begin
         step_in = 2'd1;
         acc_in  = '0;
      end else begin
         case (step_ff)
            2'd1: begin
               acc_in  = 84'(pp);
               step_in = 2'd2;
            end
            2'd2: begin
               acc_in  = acc_ff + {17'd0, pp, 17'd0};
               step_in = 2'd3;
            end
            2'd3: begin
               acc_in  = acc_ff + {pp, 34'd0};
               step_in = 2'd0;
               done_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      if (req.start) begin
         a_ff <= req.a;
         b_ff <= req.b;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ===== hw/rtl/rems_checker.sv =====
`timescale 1ns / 1ps
module rems_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accepted,
   input logic       rsp_round_done,
   input logic [31:0] rsp_attempt_count,
   input logic [31:0] rsp_exchange_count
);
   import rems_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_operation))
      else $error("request withdrawn before acceptance");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while response pending");
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_exchange_count <= rsp_attempt_count)
      else $error("exchanges exceed attempts");
   a_attempt_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_accepted || rsp_round_done) |-> rsp_attempt_count != '0)
      else $error("attempt result without count");
endmodule

bind replica_exchange_metropolis_swap rems_checker u_rems_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_operation      (req_operation),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_accepted       (rsp_accepted),
   .rsp_round_done     (rsp_round_done),
   .rsp_attempt_count  (rsp_attempt_count),
   .rsp_exchange_count (rsp_exchange_count)
);
